FILE: rtl/core/clle_pkg.sv
package clle_pkg;

	localparam int POOL_SIZE = 32;
	localparam int IDX_W     = $clog2(POOL_SIZE);
	localparam int VAL_W     = 32;
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);

	typedef enum logic [2:0] {
		OP_REINIT    = 3'd0,
		OP_NEW_LIST  = 3'd1,
		OP_INSERT    = 3'd2,
		OP_DELETE    = 3'd3,
		OP_FIND      = 3'd4,
		OP_FIND_PREV = 3'd5,
		OP_FREE_LIST = 3'd6,
		OP_READ      = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_ZERO_ARG  = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_INS2,
		S_WALK,
		S_DEL,
		S_FREE
	} ctrl_state_t;

	// datapath micro-operations
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_REBUILD,
		DP_NEW_LIST,
		DP_INS1,
		DP_INS2,
		DP_WALK_STEP,
		DP_WALK_STOP,
		DP_DEL,
		DP_FREE_STEP
	} dp_op_t;

	// link read address
	typedef enum logic [1:0] {
		AS_HEAD,
		AS_POS,
		AS_P,
		AS_T
	} addr_sel_t;

	// source of position_out
	typedef enum logic [2:0] {
		PS_ZERO,
		PS_HEAD,
		PS_T,
		PS_NX,
		PS_P,
		PS_POS
	} pos_sel_t;

	typedef struct packed {
		dp_op_t    op;
		addr_sel_t asel;
		logic      vsel_addr; // value read at link address, else at its successor
		logic      res_en;
		status_t   st;
		pos_sel_t  psel;
		logic      rd_en;
	} ctrl_cmd_t;

	typedef struct packed {
		opcode_t opc;
		logic    pos_zero;
		logic    lh_zero;
		logic    head_zero;
		logic    nx_zero;
		logic    match;
		logic    cnt_lim;
		logic    p_zero;
		logic    out_free;
	} dp_stat_t;

endpackage

FILE: rtl/core/clle_if.sv
interface clle_in_if;
	import clle_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [2:0]              opcode;
	logic signed [VAL_W-1:0] value;
	logic [IDX_W-1:0]        list_head;
	logic [IDX_W-1:0]        position;

	modport source (output valid, opcode, value, list_head, position, input ready);
	modport sink (input valid, opcode, value, list_head, position, output ready);
endinterface

interface clle_out_if;
	import clle_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic [IDX_W-1:0]        position_out;
	logic signed [VAL_W-1:0] value_out;
	logic [IDX_W-1:0]        next_out;
	logic                    is_last;

	modport source (output valid, status, position_out, value_out, next_out, is_last,
		input ready);
	modport sink (input valid, status, position_out, value_out, next_out, is_last,
		output ready);
endinterface

FILE: rtl/core/clle_dp.sv
module clle_dp
	import clle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd_c,
	input  logic [2:0]        in_opcode,
	input  logic [VAL_W-1:0]  in_value,
	input  logic [IDX_W-1:0]  in_list_head,
	input  logic [IDX_W-1:0]  in_position,
	output dp_stat_t          stat,
	clle_out_if.source        rsp
);

	logic [VAL_W-1:0] val_mem [POOL_SIZE];
	logic [IDX_W-1:0] nxt_q [POOL_SIZE];

	opcode_t          opc_q;
	logic [VAL_W-1:0] x_q;
	logic [IDX_W-1:0] lh_q, pos_q, p_q, t_q;
	logic [CNT_W-1:0] cnt_q;

	logic [IDX_W-1:0] head, rd_addr, rd_next, va;
	logic [VAL_W-1:0] rd_val;
	logic             match;

	logic             rsp_valid_q;
	status_t          status_q;
	logic [IDX_W-1:0] pos_out_q, next_out_q;
	logic [VAL_W-1:0] value_out_q;
	logic             is_last_q;
	logic [IDX_W-1:0] pos_res;

	assign head = nxt_q[0];

	always_comb begin
		unique case (cmd_c.asel)
			AS_HEAD: rd_addr = head;
			AS_POS:  rd_addr = pos_q;
			AS_P:    rd_addr = p_q;
			default: rd_addr = t_q;
		endcase
	end

	assign rd_next = nxt_q[rd_addr];
	assign va      = cmd_c.vsel_addr ? rd_addr : rd_next;
	assign rd_val  = val_mem[va];
	assign match   = (rd_val == x_q);

	assign stat.opc       = opc_q;
	assign stat.pos_zero  = (pos_q == '0);
	assign stat.lh_zero   = (lh_q == '0);
	assign stat.head_zero = (head == '0);
	assign stat.nx_zero   = (rd_next == '0);
	assign stat.match     = match;
	assign stat.cnt_lim   = (cnt_q == CNT_W'(POOL_SIZE));
	assign stat.p_zero    = (p_q == '0);
	assign stat.out_free  = !rsp_valid_q || rsp.ready;

	// link store, reset to one chained free list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				nxt_q[i] <= (i == POOL_SIZE - 1) ? '0 : IDX_W'(i + 1);
			end
		end else begin
			unique case (cmd_c.op)
				DP_REBUILD: begin
					for (int i = 0; i < POOL_SIZE; i++) begin
						nxt_q[i] <= (i == POOL_SIZE - 1) ? '0 : IDX_W'(i + 1);
					end
				end
				DP_NEW_LIST: begin
					nxt_q[0]    <= rd_next;
					nxt_q[head] <= '0;
				end
				DP_INS1: nxt_q[0] <= rd_next;
				DP_INS2: begin
					nxt_q[t_q]   <= rd_next;
					nxt_q[pos_q] <= t_q;
				end
				DP_DEL: begin
					nxt_q[p_q] <= rd_next;
					nxt_q[t_q] <= head;
					nxt_q[0]   <= t_q;
				end
				DP_FREE_STEP: begin
					nxt_q[p_q] <= head;
					nxt_q[0]   <= p_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_c.op == DP_INS1) begin
			val_mem[head] <= x_q;
		end
	end

	// operands and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case (cmd_c.op)
				DP_LOAD: begin
					opc_q <= opcode_t'(in_opcode);
					x_q   <= in_value;
					lh_q  <= in_list_head;
					pos_q <= in_position;
					p_q   <= in_list_head;
					cnt_q <= '0;
				end
				DP_INS1: t_q <= head;
				DP_WALK_STEP, DP_FREE_STEP: begin
					p_q   <= rd_next;
					cnt_q <= cnt_q + 1'b1;
				end
				DP_WALK_STOP: t_q <= rd_next;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd_c.psel)
			PS_HEAD: pos_res = head;
			PS_T:    pos_res = t_q;
			PS_NX:   pos_res = rd_next;
			PS_P:    pos_res = p_q;
			PS_POS:  pos_res = pos_q;
			default: pos_res = '0;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd_c.res_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_c.res_en) begin
			status_q    <= cmd_c.st;
			pos_out_q   <= pos_res;
			value_out_q <= cmd_c.rd_en ? rd_val : '0;
			next_out_q  <= cmd_c.rd_en ? rd_next : '0;
			is_last_q   <= cmd_c.rd_en && (rd_next == '0);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.position_out = pos_out_q;
	assign rsp.value_out    = value_out_q;
	assign rsp.next_out     = next_out_q;
	assign rsp.is_last      = is_last_q;

endmodule

FILE: rtl/core/clle_ctrl.sv
module clle_ctrl
	import clle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd_c
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic stop, found;
		stop  = stat.nx_zero || stat.match;
		found = !stat.nx_zero;

		state_d         = state_q;
		in_ready        = 1'b0;
		cmd_c.op        = DP_NOP;
		cmd_c.asel      = AS_P;
		cmd_c.vsel_addr = 1'b0;
		cmd_c.res_en    = 1'b0;
		cmd_c.st        = ST_OK;
		cmd_c.psel      = PS_ZERO;
		cmd_c.rd_en     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_c.op = DP_LOAD;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.opc)
					OP_NEW_LIST, OP_INSERT: cmd_c.asel = AS_HEAD;
					OP_READ: begin
						cmd_c.asel      = AS_POS;
						cmd_c.vsel_addr = 1'b1;
					end
					default: cmd_c.asel = AS_P;
				endcase
				if (stat.out_free) begin
					unique case (stat.opc)
						OP_REINIT: begin
							cmd_c.op     = DP_REBUILD;
							cmd_c.res_en = 1'b1;
							state_d      = S_IDLE;
						end
						OP_NEW_LIST: begin
							cmd_c.res_en = 1'b1;
							state_d      = S_IDLE;
							if (stat.head_zero) begin
								cmd_c.st = ST_EXHAUSTED;
							end else begin
								cmd_c.op   = DP_NEW_LIST;
								cmd_c.psel = PS_HEAD;
							end
						end
						OP_INSERT: begin
							if (stat.pos_zero) begin
								cmd_c.res_en = 1'b1;
								cmd_c.st     = ST_ZERO_ARG;
								state_d      = S_IDLE;
							end else if (stat.head_zero) begin
								cmd_c.res_en = 1'b1;
								cmd_c.st     = ST_EXHAUSTED;
								state_d      = S_IDLE;
							end else begin
								cmd_c.op = DP_INS1;
								state_d  = S_INS2;
							end
						end
						OP_DELETE, OP_FIND, OP_FIND_PREV: begin
							if (stat.lh_zero) begin
								cmd_c.res_en = 1'b1;
								cmd_c.st     = ST_ZERO_ARG;
								state_d      = S_IDLE;
							end else begin
								state_d = S_WALK;
							end
						end
						OP_FREE_LIST: begin
							if (stat.lh_zero) begin
								cmd_c.res_en = 1'b1;
								cmd_c.st     = ST_ZERO_ARG;
								state_d      = S_IDLE;
							end else begin
								state_d = S_FREE;
							end
						end
						default: begin
							cmd_c.res_en = 1'b1;
							state_d      = S_IDLE;
							if (stat.pos_zero) begin
								cmd_c.st = ST_ZERO_ARG;
							end else begin
								cmd_c.psel  = PS_POS;
								cmd_c.rd_en = 1'b1;
							end
						end
					endcase
				end
			end
			S_INS2: begin
				cmd_c.asel = AS_POS;
				if (stat.out_free) begin
					cmd_c.op     = DP_INS2;
					cmd_c.res_en = 1'b1;
					cmd_c.psel   = PS_T;
					state_d      = S_IDLE;
				end
			end
			S_WALK: begin
				cmd_c.asel = AS_P;
				if (!stop && !stat.cnt_lim) begin
					cmd_c.op = DP_WALK_STEP;
				end else if (stop && found && stat.opc == OP_DELETE) begin
					cmd_c.op = DP_WALK_STOP;
					state_d  = S_DEL;
				end else if (stat.out_free) begin
					cmd_c.res_en = 1'b1;
					state_d      = S_IDLE;
					if (!(stop && found)) begin
						cmd_c.st = ST_NOT_FOUND;
					end
					if (stat.opc == OP_FIND_PREV) begin
						cmd_c.psel = PS_P;
					end else if (stop && found && stat.opc == OP_FIND) begin
						cmd_c.psel = PS_NX;
					end
				end
			end
			S_DEL: begin
				cmd_c.asel = AS_T;
				if (stat.out_free) begin
					cmd_c.op     = DP_DEL;
					cmd_c.res_en = 1'b1;
					cmd_c.psel   = PS_T;
					state_d      = S_IDLE;
				end
			end
			default: begin
				cmd_c.asel = AS_P;
				if (!stat.p_zero && !stat.cnt_lim) begin
					cmd_c.op = DP_FREE_STEP;
				end else if (stat.out_free) begin
					cmd_c.res_en = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

endmodule

FILE: rtl/core/cursor_linked_list_engine_unit.sv
// Linked-list engine over a 32-node pool with a free list headed by node 0.
// One word in on cmd gives exactly one word out on rsp, in order. Words are
// taken one at a time: ready rises again once the previous word has been
// worked through, and a finished result may still sit in the output register
// waiting for rsp.ready. Insert first takes a free node, then links it in.
// Find and find previous walk the list one node per step, delete walks and
// then unlinks, and free list frees one node per step; a walk is bounded at
// 32 nodes. The walk does one link-and-value lookup per cycle from the node
// store. A node value read before it was ever written is undefined.
module cursor_linked_list_engine_unit
	import clle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	clle_in_if.sink     cmd,
	clle_out_if.source  rsp
);

	ctrl_cmd_t cmd_c;
	dp_stat_t  stat;
	logic      in_ready;

	assign cmd.ready = in_ready;

	// sequencer: walks, link updates, result hand-off
	clle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd_c    (cmd_c)
	);

	// node store, walk registers and result register
	clle_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_c        (cmd_c),
		.in_opcode    (cmd.opcode),
		.in_value     (cmd.value),
		.in_list_head (cmd.list_head),
		.in_position  (cmd.position),
		.stat         (stat),
		.rsp          (rsp)
	);

	// one word in flight: no accept straight after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("word accepted while previous word in progress");

	// results only go into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_c.res_en |-> stat.out_free)
		else $error("result written over pending output word");

	// a produced result shows up on rsp
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_c.res_en |=> rsp.valid)
		else $error("result lost");

endmodule
